// ===== hdl/ilt_pkg.sv =====
// ilt_pkg: shared constants and the command type for the indexed list table.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package ilt_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int WIDTH_DEF = 32;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 9;
  localparam int VALUE_W = 32;
  localparam int NUM_W   = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_FIND   = 3'd4
  } cmd_t;

endpackage

// ===== hdl/ilt_in_if.sv =====
// ilt_in_if: request channel of the indexed list table (valid/ready plus payload).
// Depends on ilt_pkg.
`timescale 1ns / 1ps

interface ilt_in_if;
  import ilt_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

// ===== hdl/ilt_out_if.sv =====
// ilt_out_if: result channel of the indexed list table (valid/ready plus payload).
// Depends on ilt_pkg.
`timescale 1ns / 1ps

interface ilt_out_if;
  import ilt_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok;
  logic [NUM_W-1:0] match_number;
  logic [NUM_W-1:0] element_count;

  modport source (output valid, ok, match_number, element_count, input ready);
  modport sink   (input valid, ok, match_number, element_count, output ready);
endinterface

// ===== hdl/indexed_list_table_top.sv =====
// indexed_list_table_top: packed ordered list with push, pop, insert, delete and find.
// Depends on ilt_pkg, ilt_in_if and ilt_out_if.
//
//   channel   | port    | direction | payload
//   ----------+---------+-----------+-------------------------------------
//   request   | in_req  | sink      | command, position, value
//   result    | out_rsp | source    | ok, match_number, element_count
//
// Push, pop, insert past the end and failing requests go straight from idle to S_FIN.
// Insert shifts the words from the position onward up by one, delete shifts those after it down;
// find compares words from the start position until a match or the end of the list.
// Words move or are compared one per cycle via the store's single read and single write port.
// One request at a time; in_req.ready is high only when idle. The result register holds
// a finished result while the next request is taken; a request waits in its last cycle
// while that register is still full. Reset empties the list at once.
`timescale 1ns / 1ps

module indexed_list_table_top #(
  parameter int DEPTH = ilt_pkg::DEPTH_DEF,
  parameter int WIDTH = ilt_pkg::WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ilt_in_if.sink    in_req,
  ilt_out_if.source out_rsp
);
  import ilt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_FIND  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  logic [WIDTH-1:0] word_mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    last_r, last_nxt;
  logic [CW-1:0]    pidx_r, pidx_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic             issue_r, issue_nxt;
  logic             pend_r, pend_nxt;
  logic             ins_r, ins_nxt;
  logic [WIDTH-1:0] val_r, val_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic [XW-1:0]    res_match_r, res_match_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [NUM_W-1:0] out_match_r, out_match_nxt;
  logic [NUM_W-1:0] out_count_r, out_count_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [WIDTH-1:0] wdata;
  logic [AW-1:0]    raddr;

  logic [WIDTH-1:0] in_val;
  logic [XW-1:0]    posx, countx;
  logic             hit;

  generate
    if (WIDTH <= VALUE_W) begin : g_val_trunc
      assign in_val = in_req.value[WIDTH-1:0];
    end else begin : g_val_ext
      assign in_val = {{(WIDTH - VALUE_W){1'b0}}, in_req.value};
    end
  endgenerate

  assign posx       = XW'(in_req.position);
  assign countx     = XW'(count_r);
  assign hit        = pend_r && (rdata_r == val_r);

  assign in_req.ready          = (state_r == S_IDLE);
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.ok            = out_ok_r;
  assign out_rsp.match_number  = out_match_r;
  assign out_rsp.element_count = out_count_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    pidx_nxt      = pidx_r;
    pos_nxt       = pos_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    ins_nxt       = ins_r;
    val_nxt       = val_r;
    res_ok_nxt    = res_ok_r;
    res_match_nxt = res_match_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_ok_nxt    = out_ok_r;
    out_match_nxt = out_match_r;
    out_count_nxt = out_count_r;
    we            = 1'b0;
    waddr         = count_r[AW-1:0];
    wdata         = in_val;
    raddr         = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          val_nxt       = in_val;
          pos_nxt       = CW'(posx);
          res_ok_nxt    = 1'b0;
          res_match_nxt = '0;
          state_nxt     = S_FIN;
          unique case (cmd_t'(in_req.command))
            CMD_PUSH: begin
              if (count_r < CW'(DEPTH)) begin
                we         = 1'b1;
                count_nxt  = count_r + 1'b1;
                res_ok_nxt = 1'b1;
              end
            end
            CMD_POP: begin
              if (count_r != '0) begin
                count_nxt  = count_r - 1'b1;
                res_ok_nxt = 1'b1;
              end
            end
            CMD_INSERT: begin
              if (count_r < CW'(DEPTH)) begin
                if (posx >= countx) begin
                  we         = 1'b1;
                  count_nxt  = count_r + 1'b1;
                  res_ok_nxt = 1'b1;
                end else begin
                  ins_nxt   = 1'b1;
                  idx_nxt   = count_r - 1'b1;
                  last_nxt  = CW'(posx);
                  issue_nxt = 1'b1;
                  state_nxt = S_SHIFT;
                end
              end
            end
            CMD_DELETE: begin
              if (posx < countx) begin
                ins_nxt   = 1'b0;
                idx_nxt   = CW'(posx) + 1'b1;
                last_nxt  = count_r - 1'b1;
                issue_nxt = (posx + 1'b1) < countx;
                state_nxt = S_SHIFT;
              end
            end
            CMD_FIND: begin
              if (posx != '0 && posx <= countx) begin
                idx_nxt   = CW'(posx - 1'b1);
                state_nxt = S_FIND;
              end
            end
            default: ;
          endcase
        end
      end

      S_SHIFT: begin
        if (issue_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          if (idx_r == last_r) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = ins_r ? idx_r - 1'b1 : idx_r + 1'b1;
          end
        end
        if (pend_r) begin
          we    = 1'b1;
          waddr = ins_r ? AW'(pidx_r + 1'b1) : AW'(pidx_r - 1'b1);
          wdata = rdata_r;
        end else if (!issue_r) begin
          res_ok_nxt = 1'b1;
          if (ins_r) begin
            we        = 1'b1;
            waddr     = pos_r[AW-1:0];
            wdata     = val_r;
            count_nxt = count_r + 1'b1;
          end else begin
            count_nxt = count_r - 1'b1;
          end
          state_nxt = S_FIN;
        end
      end

      S_FIND: begin
        pend_nxt = (idx_r < count_r);
        pidx_nxt = idx_r;
        idx_nxt  = idx_r + 1'b1;
        if (hit) begin
          res_ok_nxt    = 1'b1;
          res_match_nxt = XW'(pidx_r) + 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = S_FIN;
        end else if (idx_r >= count_r) begin
          pend_nxt  = 1'b0;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_match_nxt = res_match_r[NUM_W-1:0];
          out_count_nxt = countx[NUM_W-1:0];
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      word_mem[waddr] <= wdata;
    end
    rdata_r <= word_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    last_r      <= last_nxt;
    pidx_r      <= pidx_nxt;
    pos_r       <= pos_nxt;
    ins_r       <= ins_nxt;
    val_r       <= val_nxt;
    res_ok_r    <= res_ok_nxt;
    res_match_r <= res_match_nxt;
    out_ok_r    <= out_ok_nxt;
    out_match_r <= out_match_nxt;
    out_count_r <= out_count_nxt;
  end

endmodule

// ===== bench/indexed_list_table_top_tb.sv =====
// indexed_list_table_top_tb: self-checking bench for the indexed list table.
// Drives push/pop/insert/delete/find requests, mirrors the list and checks each result.
// Depends on ilt_pkg, ilt_in_if, ilt_out_if and indexed_list_table_top.
`timescale 1ns / 1ps

module indexed_list_table_top_tb;
  import ilt_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int WIDTH       = WIDTH_DEF;
  localparam int TAIL_CYCLES = DEPTH + 50;
  localparam int POOL_SIZE   = 8;
  localparam int SMALL_LIST  = 16;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    logic             ok;
    logic [NUM_W-1:0] match_number;
    logic [NUM_W-1:0] element_count;
  } list_rsp_t;

  logic clk;
  logic rst_n;

  ilt_in_if  req_ch ();
  ilt_out_if rsp_ch ();

  indexed_list_table_top #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  list_req_t          request_backlog[$];
  list_rsp_t          awaited_results[$];
  list_req_t          drv_req;
  logic               drv_valid;
  list_rsp_t          want_rsp;
  logic [WIDTH-1:0]   mirror_words [DEPTH];
  int                 mirror_count;
  int                 planned_count;
  logic [VALUE_W-1:0] word_pool [POOL_SIZE];
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;
  int unsigned        fault_count;

  // Applies one request to the mirrored list and returns the result it should give.
  function automatic list_rsp_t list_update(list_req_t r);
    list_rsp_t        rsp;
    int               slot;
    int               pos;
    logic [WIDTH-1:0] word;
    rsp  = '0;
    pos  = int'(r.position);
    word = r.value[WIDTH-1:0];
    case (r.command)
      CMD_PUSH, CMD_INSERT: begin
        if (mirror_count < DEPTH) begin
          slot = (r.command == CMD_INSERT && pos < mirror_count) ? pos : mirror_count;
          for (int i = mirror_count; i > slot; i--) mirror_words[i] = mirror_words[i - 1];
          mirror_words[slot] = word;
          mirror_count++;
          rsp.ok = 1'b1;
        end
      end
      CMD_POP: begin
        if (mirror_count > 0) begin
          mirror_count--;
          rsp.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos < mirror_count) begin
          for (int i = pos; i + 1 < mirror_count; i++) mirror_words[i] = mirror_words[i + 1];
          mirror_count--;
          rsp.ok = 1'b1;
        end
      end
      CMD_FIND: begin
        if (pos >= 1 && pos <= mirror_count) begin
          for (int i = pos - 1; i < mirror_count; i++) begin
            if (mirror_words[i] == word) begin
              rsp.match_number = NUM_W'(i + 1);
              rsp.ok = 1'b1;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    rsp.element_count = NUM_W'(mirror_count);
    return rsp;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_word();
    if ($urandom_range(0, 3) != 0) return word_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Queues a request and tracks the list length it should leave behind.
  task automatic plan_request(input logic [CMD_W-1:0] command, input int position,
                              input logic [VALUE_W-1:0] value);
    list_req_t r;
    r.command  = command;
    r.position = POS_W'(position);
    r.value    = value;
    request_backlog.push_back(r);
    case (command)
      CMD_PUSH, CMD_INSERT: if (planned_count < DEPTH) planned_count++;
      CMD_POP:              if (planned_count > 0) planned_count--;
      CMD_DELETE:           if (position < planned_count) planned_count--;
      default: ;
    endcase
  endtask

  task automatic wait_until_drained();
    while (request_backlog.size() != 0 || drv_valid || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n           = 1'b0;
    drv_valid       = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.command  = '0;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    mirror_count    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) awaited_results.push_back(list_update(drv_req));
      drv_valid = req_ch.valid && !req_ch.ready;
      if (!drv_valid && request_backlog.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        drv_req          = request_backlog.pop_front();
        drv_valid        = 1'b1;
        req_ch.command  <= drv_req.command;
        req_ch.position <= drv_req.position;
        req_ch.value    <= drv_req.value;
      end
      req_ch.valid <= drv_valid;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding");
          fault_count++;
        end else begin
          want_rsp = awaited_results.pop_front();
          if (rsp_ch.ok !== want_rsp.ok) begin
            $error("ok: expected %0d, got %0d", want_rsp.ok, rsp_ch.ok);
            fault_count++;
          end
          if (rsp_ch.match_number !== want_rsp.match_number) begin
            $error("match_number: expected %0d, got %0d",
                   want_rsp.match_number, rsp_ch.match_number);
            fault_count++;
          end
          if (rsp_ch.element_count !== want_rsp.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   want_rsp.element_count, rsp_ch.element_count);
            fault_count++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    int               roll;
    int               position;
    logic [CMD_W-1:0] command;
    fault_count    = 0;
    planned_count  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    word_pool[0]   = '0;
    word_pool[1]   = '1;
    for (int k = 2; k < POOL_SIZE; k++) word_pool[k] = $urandom;
    wait (rst_n === 1'b1);

    // empty list, insert past end, middle insert, find edges, delete edges, spare codes
    plan_request(CMD_POP, 0, word_pool[2]);
    plan_request(CMD_DELETE, 0, word_pool[2]);
    plan_request(CMD_FIND, 1, word_pool[0]);
    plan_request(CMD_INSERT, 2 ** POS_W - 1, word_pool[2]);
    plan_request(CMD_PUSH, 0, word_pool[0]);
    plan_request(CMD_PUSH, 0, word_pool[1]);
    plan_request(CMD_INSERT, 0, word_pool[3]);
    plan_request(CMD_INSERT, 2, word_pool[2]);
    plan_request(CMD_FIND, 1, word_pool[2]);
    plan_request(CMD_FIND, 3, word_pool[2]);
    plan_request(CMD_FIND, 4, word_pool[2]);
    plan_request(CMD_FIND, 0, word_pool[1]);
    plan_request(CMD_FIND, planned_count, word_pool[1]);
    plan_request(CMD_FIND, planned_count + 1, word_pool[1]);
    plan_request(CMD_FIND, 2 ** POS_W - 1, word_pool[1]);
    plan_request(CMD_DELETE, planned_count - 1, '0);
    plan_request(CMD_DELETE, planned_count, '0);
    plan_request(CMD_DELETE, 0, '0);
    for (int c = CMD_FIND + 1; c < 2 ** CMD_W; c++) plan_request(CMD_W'(c), 2 ** POS_W - 1, '1);
    plan_request(CMD_POP, 0, '0);
    plan_request(CMD_INSERT, planned_count, word_pool[4]);

    for (int phase = 0; phase < 4; phase++) begin
      wait_until_drained();
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase

      // short list, mixed requests
      repeat (110) begin
        roll = $urandom_range(0, 99);
        if (roll < 20)      command = CMD_PUSH;
        else if (roll < 38) command = CMD_POP;
        else if (roll < 56) command = CMD_INSERT;
        else if (roll < 74) command = CMD_DELETE;
        else if (roll < 96) command = CMD_FIND;
        else                command = CMD_W'($urandom_range(CMD_FIND + 1, 2 ** CMD_W - 1));
        if (planned_count > SMALL_LIST && (command == CMD_PUSH || command == CMD_INSERT))
          command = CMD_DELETE;
        if ($urandom_range(0, 9) == 0) position = $urandom_range(0, 2 ** POS_W - 1);
        else                           position = $urandom_range(0, planned_count + 1);
        plan_request(command, position, pick_word());
      end

      // fill to capacity, exercise the full list, then empty it
      if (phase == 2) begin
        while (planned_count < DEPTH)
          plan_request(CMD_PUSH, $urandom_range(0, 2 ** POS_W - 1), pick_word());
        plan_request(CMD_PUSH, 0, pick_word());
        plan_request(CMD_INSERT, 0, pick_word());
        plan_request(CMD_INSERT, DEPTH + 44, pick_word());
        plan_request(CMD_FIND, 1, word_pool[$urandom_range(0, POOL_SIZE - 1)]);
        plan_request(CMD_FIND, DEPTH, pick_word());
        plan_request(CMD_DELETE, DEPTH - 1, '0);
        plan_request(CMD_INSERT, 0, pick_word());
        plan_request(CMD_DELETE, 0, '0);
        while (planned_count > 0) begin
          roll = $urandom_range(0, 99);
          if (roll < 8)
            plan_request(CMD_DELETE, $urandom_range(0, planned_count - 1), '0);
          else if (roll < 18)
            plan_request(CMD_FIND, $urandom_range(0, planned_count + 1), pick_word());
          else
            plan_request(CMD_POP, $urandom_range(0, 2 ** POS_W - 1), $urandom);
        end
        plan_request(CMD_POP, 0, '0);
      end
    end

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
